[rtl/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// cfp_pkg: shared widths, codes and types
// Widths of the circle datapath, derived from the coordinate width, plus the
// status codes and the item structs that travel between the pipeline parts.
// ----------------------------------------------------------------------------
package cfp_pkg;

  // Coordinate width (signed, sixteen fraction bits that cancel in the maths)
  localparam int CW    = 32;
  // Point differences and their products
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  // Limb width for the split multiplications
  localparam int LW    = DW;
  // Signed difference times an unsigned limb
  localparam int PPW   = DW + LW + 1;
  // Cross product and the high limb of its square
  localparam int XW    = PW + 1;
  localparam int CHW   = XW - LW;
  localparam int CPW   = 2 * CHW;
  // Centre numerators, divisor and divisor magnitude
  localparam int NW    = DW + PW + 1;
  localparam int DDW   = XW + 1;
  localparam int DMW   = XW;
  // Quotient and radius bits resolved by the iteration pipeline
  localparam int QB    = CW + 2;
  localparam int NSTEP = QB;
  // Radius numerator |u|^2 |v|^2 |w|^2 and its limbs
  localparam int UVW    = 2 * PW;
  localparam int ULIMBS = UVW / LW;
  localparam int WLIMBS = PW / LW;
  localparam int TW     = (ULIMBS + 1) * LW;
  localparam int SW     = TW + LW;
  // Squared divisor and the radius search accumulators
  localparam int D2W   = ULIMBS * LW + 2;
  localparam int YW    = D2W + QB;
  localparam int QAW   = D2W + 2 * QB + 2;
  // Signed quotient and centre sum
  localparam int QSW   = QB + 2;
  localparam int SUMW  = QB + 3;

  // Divisor that turns the offset to the second point into the midpoint
  localparam int HALF_DIV = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_SAT       = 2'd2
  } status_t;

  // Operands handed to the divide and square-root pipeline
  typedef struct packed {
    logic                  collinear;
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  ay;
    logic [NW-1:0]         nmx;
    logic [NW-1:0]         nmy;
    logic                  negx;
    logic                  negy;
    logic [DMW-1:0]        dmag;
    logic                  bigx;
    logic                  bigy;
    logic [SW-1:0]         s;
    logic [D2W-1:0]        d2;
  } it_in_t;

  // Operands plus the partial results of the iteration
  typedef struct packed {
    it_in_t          op;
    logic [NW-1:0]   rx;
    logic [NW-1:0]   ry;
    logic [QB-1:0]   qx;
    logic [QB-1:0]   qy;
    logic [QAW-1:0]  acc;
    logic [YW-1:0]   yacc;
    logic [QB-1:0]   r;
  } it_t;

endpackage

[rtl/cfp_front.sv]
// ----------------------------------------------------------------------------
// cfp_front: product pipeline
// Eight stages that form the point differences, their products, the centre
// numerators, the divisor and the radius numerator for the iteration stages.
// ----------------------------------------------------------------------------
module cfp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic                             kind,
  input  logic signed [cfp_pkg::CW-1:0]    ax,
  input  logic signed [cfp_pkg::CW-1:0]    ay,
  input  logic signed [cfp_pkg::CW-1:0]    bx,
  input  logic signed [cfp_pkg::CW-1:0]    by_coord,
  input  logic signed [cfp_pkg::CW-1:0]    cx,
  input  logic signed [cfp_pkg::CW-1:0]    cy,
  output logic                             o_valid,
  output cfp_pkg::it_in_t                  o_op
);

  localparam int CW     = cfp_pkg::CW;
  localparam int DW     = cfp_pkg::DW;
  localparam int PW     = cfp_pkg::PW;
  localparam int LW     = cfp_pkg::LW;
  localparam int PPW    = cfp_pkg::PPW;
  localparam int XW     = cfp_pkg::XW;
  localparam int CPW    = cfp_pkg::CPW;
  localparam int NW     = cfp_pkg::NW;
  localparam int DDW    = cfp_pkg::DDW;
  localparam int DMW    = cfp_pkg::DMW;
  localparam int QB     = cfp_pkg::QB;
  localparam int UVW    = cfp_pkg::UVW;
  localparam int ULIMBS = cfp_pkg::ULIMBS;
  localparam int WLIMBS = cfp_pkg::WLIMBS;
  localparam int TW     = cfp_pkg::TW;
  localparam int SW     = cfp_pkg::SW;
  localparam int D2W    = cfp_pkg::D2W;

  // signed difference times an unsigned limb
  function automatic logic signed [PPW-1:0] smul(input logic signed [DW-1:0] a,
                                                 input logic [LW-1:0] b);
    return PPW'(a) * PPW'($signed({1'b0, b}));
  endfunction

  logic [7:0] vld;

  // stage 1
  logic                 s1_kind;
  logic signed [CW-1:0] s1_ax, s1_ay;
  logic signed [DW-1:0] s1_ux, s1_uy, s1_vx, s1_vy, s1_wx, s1_wy;
  // stage 2
  logic                 s2_kind;
  logic signed [CW-1:0] s2_ax, s2_ay;
  logic signed [DW-1:0] s2_ux, s2_uy, s2_vx, s2_vy;
  logic signed [PW-1:0] s2_puv, s2_pvu;
  logic signed [PW-1:0] s2_qux, s2_quy, s2_qvx, s2_qvy, s2_qwx, s2_qwy;
  // stage 3
  logic                 s3_kind, s3_col;
  logic signed [CW-1:0] s3_ax, s3_ay;
  logic signed [DW-1:0] s3_ux, s3_uy, s3_vx, s3_vy;
  logic signed [XW-1:0] s3_cr;
  logic [PW-1:0]        s3_u2, s3_v2, s3_w2;
  // stage 4
  logic                  s4_kind, s4_col;
  logic signed [CW-1:0]  s4_ax, s4_ay;
  logic signed [DW-1:0]  s4_ux, s4_uy;
  logic signed [XW-1:0]  s4_cr;
  logic [PW-1:0]         s4_u2, s4_w2;
  logic signed [PPW-1:0] s4_vyu_l, s4_vyu_h, s4_uyv_l, s4_uyv_h;
  logic signed [PPW-1:0] s4_uxv_l, s4_uxv_h, s4_vxu_l, s4_vxu_h;
  logic [2*LW-1:0]       s4_uv_ll, s4_uv_lh, s4_uv_hl, s4_uv_hh, s4_c_ll;
  logic signed [CPW-1:0] s4_c_hl, s4_c_hh;
  // stage 5
  logic                  s5_kind, s5_col;
  logic signed [CW-1:0]  s5_ax, s5_ay;
  logic [PW-1:0]         s5_u2, s5_w2;
  logic signed [NW-1:0]  s5_nx, s5_ny;
  logic [UVW-1:0]        s5_uv;
  logic signed [DDW-1:0] s5_dd;
  logic [D2W-1:0]        s5_d2;
  // stage 6
  logic                  s6_kind, s6_col;
  logic signed [CW-1:0]  s6_ax, s6_ay;
  logic [PW-1:0]         s6_u2;
  logic [D2W-1:0]        s6_d2;
  logic [NW-1:0]         s6_nmx, s6_nmy;
  logic                  s6_negx, s6_negy;
  logic [DMW-1:0]        s6_dmag;
  logic [2*LW-1:0]       s6_p [ULIMBS][WLIMBS];
  // stage 7
  logic                  s7_kind, s7_col;
  logic signed [CW-1:0]  s7_ax, s7_ay;
  logic [PW-1:0]         s7_u2;
  logic [D2W-1:0]        s7_d2;
  logic [NW-1:0]         s7_nmx, s7_nmy;
  logic                  s7_negx, s7_negy;
  logic [DMW-1:0]        s7_dmag;
  logic                  s7_bigx, s7_bigy;
  logic [TW-1:0]         s7_t [WLIMBS];
  // stage 8
  cfp_pkg::it_in_t       s8;

  // combinational helpers
  logic                  plain;
  logic signed [NW-1:0]  nx_c, ny_c;
  logic [UVW-1:0]        uv_c;
  logic [D2W-1:0]        c2_c;
  logic [TW-1:0]         t_c [WLIMBS];
  logic [NW:0]           dlim_c;

  // advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  // stage 1: differences from the first and second points
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind <= kind;
      s1_ax   <= ax;
      s1_ay   <= ay;
      s1_ux   <= DW'(bx) - DW'(ax);
      s1_uy   <= DW'(by_coord) - DW'(ay);
      s1_vx   <= DW'(cx) - DW'(ax);
      s1_vy   <= DW'(cy) - DW'(ay);
      s1_wx   <= DW'(cx) - DW'(bx);
      s1_wy   <= DW'(cy) - DW'(by_coord);
    end
  end

  // stage 2: cross terms and squares
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind <= s1_kind;
      s2_ax   <= s1_ax;
      s2_ay   <= s1_ay;
      s2_ux   <= s1_ux;
      s2_uy   <= s1_uy;
      s2_vx   <= s1_vx;
      s2_vy   <= s1_vy;
      s2_puv  <= s1_ux * s1_vy;
      s2_pvu  <= s1_uy * s1_vx;
      s2_qux  <= s1_ux * s1_ux;
      s2_quy  <= s1_uy * s1_uy;
      s2_qvx  <= s1_vx * s1_vx;
      s2_qvy  <= s1_vy * s1_vy;
      s2_qwx  <= s1_wx * s1_wx;
      s2_qwy  <= s1_wy * s1_wy;
    end
  end

  // stage 3: cross product, squared side lengths, collinear test
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kind <= s2_kind;
      s3_col  <= s2_kind && (s2_puv == s2_pvu);
      s3_ax   <= s2_ax;
      s3_ay   <= s2_ay;
      s3_ux   <= s2_ux;
      s3_uy   <= s2_uy;
      s3_vx   <= s2_vx;
      s3_vy   <= s2_vy;
      s3_cr   <= XW'(s2_puv) - XW'(s2_pvu);
      s3_u2   <= $unsigned(s2_qux) + $unsigned(s2_quy);
      s3_v2   <= $unsigned(s2_qvx) + $unsigned(s2_qvy);
      s3_w2   <= $unsigned(s2_qwx) + $unsigned(s2_qwy);
    end
  end

  // stage 4: limb products for the numerators, |u|^2 |v|^2 and the cross square
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_kind  <= s3_kind;
      s4_col   <= s3_col;
      s4_ax    <= s3_ax;
      s4_ay    <= s3_ay;
      s4_ux    <= s3_ux;
      s4_uy    <= s3_uy;
      s4_cr    <= s3_cr;
      s4_u2    <= s3_u2;
      s4_w2    <= s3_w2;
      s4_vyu_l <= smul(s3_vy, s3_u2[LW-1:0]);
      s4_vyu_h <= smul(s3_vy, s3_u2[PW-1:LW]);
      s4_uyv_l <= smul(s3_uy, s3_v2[LW-1:0]);
      s4_uyv_h <= smul(s3_uy, s3_v2[PW-1:LW]);
      s4_uxv_l <= smul(s3_ux, s3_v2[LW-1:0]);
      s4_uxv_h <= smul(s3_ux, s3_v2[PW-1:LW]);
      s4_vxu_l <= smul(s3_vx, s3_u2[LW-1:0]);
      s4_vxu_h <= smul(s3_vx, s3_u2[PW-1:LW]);
      s4_uv_ll <= s3_u2[LW-1:0] * s3_v2[LW-1:0];
      s4_uv_lh <= s3_u2[LW-1:0] * s3_v2[PW-1:LW];
      s4_uv_hl <= s3_u2[PW-1:LW] * s3_v2[LW-1:0];
      s4_uv_hh <= s3_u2[PW-1:LW] * s3_v2[PW-1:LW];
      s4_c_ll  <= s3_cr[LW-1:0] * s3_cr[LW-1:0];
      s4_c_hl  <= CPW'($signed(s3_cr[XW-1:LW])) * CPW'($signed({1'b0, s3_cr[LW-1:0]}));
      s4_c_hh  <= CPW'($signed(s3_cr[XW-1:LW])) * CPW'($signed(s3_cr[XW-1:LW]));
    end
  end

  // stage 5 logic: gather the limb products
  always_comb begin
    plain = !s4_kind || s4_col;
    nx_c  = (NW'(s4_vyu_h) <<< LW) + NW'(s4_vyu_l)
          - (NW'(s4_uyv_h) <<< LW) - NW'(s4_uyv_l);
    ny_c  = (NW'(s4_uxv_h) <<< LW) + NW'(s4_uxv_l)
          - (NW'(s4_vxu_h) <<< LW) - NW'(s4_vxu_l);
    uv_c  = (UVW'(s4_uv_hh) << (2 * LW))
          + ((UVW'(s4_uv_hl) + UVW'(s4_uv_lh)) << LW)
          + UVW'(s4_uv_ll);
    c2_c  = (D2W'(s4_c_hh) << (2 * LW)) + (D2W'(s4_c_hl) << (LW + 1)) + D2W'(s4_c_ll);
  end

  // stage 5: numerators and divisor, the midpoint case divides the offset by two
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_kind <= s4_kind;
      s5_col  <= s4_col;
      s5_ax   <= s4_ax;
      s5_ay   <= s4_ay;
      s5_u2   <= s4_u2;
      s5_w2   <= s4_w2;
      s5_uv   <= uv_c;
      if (s4_kind) begin
        s5_nx <= nx_c;
        s5_ny <= ny_c;
      end else begin
        s5_nx <= NW'(s4_ux);
        s5_ny <= NW'(s4_uy);
      end
      if (plain) begin
        s5_dd <= DDW'(cfp_pkg::HALF_DIV);
        s5_d2 <= D2W'(cfp_pkg::HALF_DIV * cfp_pkg::HALF_DIV);
      end else begin
        s5_dd <= DDW'(s4_cr) <<< 1;
        s5_d2 <= c2_c << 2;
      end
    end
  end

  // stage 6: magnitudes and signs, limb products of the radius numerator
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_kind <= s5_kind;
      s6_col  <= s5_col;
      s6_ax   <= s5_ax;
      s6_ay   <= s5_ay;
      s6_u2   <= s5_u2;
      s6_d2   <= s5_d2;
      s6_nmx  <= s5_nx[NW-1] ? NW'(-s5_nx) : NW'(s5_nx);
      s6_nmy  <= s5_ny[NW-1] ? NW'(-s5_ny) : NW'(s5_ny);
      s6_negx <= s5_nx[NW-1] ^ s5_dd[DDW-1];
      s6_negy <= s5_ny[NW-1] ^ s5_dd[DDW-1];
      s6_dmag <= s5_dd[DDW-1] ? DMW'(-s5_dd) : DMW'(s5_dd);
      for (int i = 0; i < ULIMBS; i++) begin
        for (int j = 0; j < WLIMBS; j++) begin
          s6_p[i][j] <= s5_uv[i*LW +: LW] * s5_w2[j*LW +: LW];
        end
      end
    end
  end

  // stage 7 logic: column sums and the quotient range check
  always_comb begin
    for (int j = 0; j < WLIMBS; j++) begin
      t_c[j] = '0;
      for (int i = 0; i < ULIMBS; i++) begin
        t_c[j] = t_c[j] + (TW'(s6_p[i][j]) << (i * LW));
      end
    end
    dlim_c = (NW + 1)'(s6_dmag) << QB;
  end

  // stage 7
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_kind <= s6_kind;
      s7_col  <= s6_col;
      s7_ax   <= s6_ax;
      s7_ay   <= s6_ay;
      s7_u2   <= s6_u2;
      s7_d2   <= s6_d2;
      s7_nmx  <= s6_nmx;
      s7_nmy  <= s6_nmy;
      s7_negx <= s6_negx;
      s7_negy <= s6_negy;
      s7_dmag <= s6_dmag;
      s7_bigx <= {1'b0, s6_nmx} >= dlim_c;
      s7_bigy <= {1'b0, s6_nmy} >= dlim_c;
      for (int j = 0; j < WLIMBS; j++) begin
        s7_t[j] <= t_c[j];
      end
    end
  end

  // stage 8: radius numerator, the midpoint case takes |u|^2
  always_ff @(posedge clk) begin
    if (adv) begin
      s8.collinear <= s7_col;
      s8.ax        <= s7_ax;
      s8.ay        <= s7_ay;
      s8.nmx       <= s7_nmx;
      s8.nmy       <= s7_nmy;
      s8.negx      <= s7_negx;
      s8.negy      <= s7_negy;
      s8.dmag      <= s7_dmag;
      s8.bigx      <= s7_bigx;
      s8.bigy      <= s7_bigy;
      s8.d2        <= s7_d2;
      if (s7_kind) begin
        s8.s <= SW'(s7_t[0]) + (SW'(s7_t[1]) << LW);
      end else begin
        s8.s <= SW'(s7_u2);
      end
    end
  end

  assign o_valid = vld[7];
  assign o_op    = s8;

endmodule

[rtl/cfp_iter.sv]
// ----------------------------------------------------------------------------
// cfp_iter: divide and square-root stages
// One quotient bit of each centre offset and one radius bit per stage. The
// radius bit search keeps r^2*d2 and r*d2 so each stage needs adds only.
// ----------------------------------------------------------------------------
module cfp_iter (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  cfp_pkg::it_in_t  in_op,
  output logic             o_valid,
  output cfp_pkg::it_t     o_st
);

  localparam int NW    = cfp_pkg::NW;
  localparam int QAW   = cfp_pkg::QAW;
  localparam int YW    = cfp_pkg::YW;
  localparam int NSTEP = cfp_pkg::NSTEP;

  cfp_pkg::it_t st [NSTEP];
  logic [NSTEP-1:0] vs;

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    localparam int B = NSTEP - 1 - g;
    cfp_pkg::it_t cur, nxt;
    logic         cur_v;
    logic [NW:0]  dsh;
    logic [QAW-1:0] cand;

    if (g == 0) begin : g_first
      // load the remainders with the numerator magnitudes
      always_comb begin
        cur      = '0;
        cur.op   = in_op;
        cur.rx   = in_op.nmx;
        cur.ry   = in_op.nmy;
      end
      assign cur_v = in_valid;
    end else begin : g_rest
      assign cur   = st[g-1];
      assign cur_v = vs[g-1];
    end

    // settle one quotient bit of each offset and one radius bit
    always_comb begin
      nxt  = cur;
      dsh  = (NW + 1)'(cur.op.dmag) << B;
      if ({1'b0, cur.rx} >= dsh) begin
        nxt.rx    = NW'({1'b0, cur.rx} - dsh);
        nxt.qx[B] = 1'b1;
      end
      if ({1'b0, cur.ry} >= dsh) begin
        nxt.ry    = NW'({1'b0, cur.ry} - dsh);
        nxt.qy[B] = 1'b1;
      end
      cand = cur.acc + (QAW'(cur.yacc) << (B + 1)) + (QAW'(cur.op.d2) << (2 * B));
      if (cand <= QAW'(cur.op.s)) begin
        nxt.acc  = cand;
        nxt.yacc = cur.yacc + (YW'(cur.op.d2) << B);
        nxt.r[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[g] <= nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[g] <= 1'b0;
      end else if (adv) begin
        vs[g] <= cur_v;
      end
    end
  end

  assign o_valid = vs[NSTEP-1];
  assign o_st    = st[NSTEP-1];

endmodule

[rtl/cfp_final.sv]
// ----------------------------------------------------------------------------
// cfp_final: result stages
// Applies floor rounding to the quotients, adds the first point, saturates
// and forms the status code. The second stage is the output register.
// ----------------------------------------------------------------------------
module cfp_final (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  cfp_pkg::it_t                   in_st,
  output logic                           o_valid,
  output logic signed [cfp_pkg::CW-1:0]  o_center_x,
  output logic signed [cfp_pkg::CW-1:0]  o_center_y,
  output logic [cfp_pkg::CW-1:0]         o_radius,
  output cfp_pkg::status_t               o_status
);

  localparam int CW   = cfp_pkg::CW;
  localparam int QB   = cfp_pkg::QB;
  localparam int QSW  = cfp_pkg::QSW;
  localparam int SUMW = cfp_pkg::SUMW;

  typedef struct packed {
    logic          sat;
    logic [CW-1:0] val;
  } clamp_t;

  // clamp a centre sum to the coordinate range
  function automatic clamp_t clamp(input logic signed [SUMW-1:0] sum,
                                   input logic big, input logic neg);
    clamp_t res;
    logic   hi_ones, hi_zeros;
    hi_ones  = &sum[SUMW-1:CW-1];
    hi_zeros = ~|sum[SUMW-1:CW-1];
    res.sat  = big || !(hi_ones || hi_zeros);
    res.val  = sum[CW-1:0];
    if (res.sat) begin
      if (big ? neg : sum[SUMW-1]) begin
        res.val = {1'b1, {(CW-1){1'b0}}};
      end else begin
        res.val = {1'b0, {(CW-1){1'b1}}};
      end
    end
    return res;
  endfunction

  logic                  f1_v;
  logic                  f1_col, f1_bigx, f1_bigy, f1_negx, f1_negy, f1_rsat;
  logic signed [CW-1:0]  f1_ax, f1_ay;
  logic signed [QSW-1:0] f1_qx, f1_qy;
  logic [CW-1:0]         f1_rad;

  logic signed [QSW-1:0] qx_c, qy_c;
  logic                  rsat_c;
  clamp_t                clx, cly;

  // floor rounding: a negative quotient with remainder drops one more
  always_comb begin
    qx_c = $signed({2'b00, in_st.qx});
    qy_c = $signed({2'b00, in_st.qy});
    if (in_st.op.negx) begin
      qx_c = -qx_c - QSW'(in_st.rx != '0);
    end
    if (in_st.op.negy) begin
      qy_c = -qy_c - QSW'(in_st.ry != '0);
    end
    rsat_c = |in_st.r[QB-1:CW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_col  <= in_st.op.collinear;
      f1_bigx <= in_st.op.bigx;
      f1_bigy <= in_st.op.bigy;
      f1_negx <= in_st.op.negx;
      f1_negy <= in_st.op.negy;
      f1_ax   <= in_st.op.ax;
      f1_ay   <= in_st.op.ay;
      f1_qx   <= qx_c;
      f1_qy   <= qy_c;
      f1_rsat <= rsat_c;
      f1_rad  <= rsat_c ? '1 : in_st.r[CW-1:0];
    end
  end

  always_comb begin
    clx = clamp(SUMW'(f1_ax) + SUMW'(f1_qx), f1_bigx, f1_negx);
    cly = clamp(SUMW'(f1_ay) + SUMW'(f1_qy), f1_bigy, f1_negy);
  end

  // output register: collinear points give zeros
  always_ff @(posedge clk) begin
    if (adv) begin
      if (f1_col) begin
        o_center_x <= '0;
        o_center_y <= '0;
        o_radius   <= '0;
        o_status   <= cfp_pkg::ST_COLLINEAR;
      end else begin
        o_center_x <= clx.val;
        o_center_y <= cly.val;
        o_radius   <= f1_rad;
        o_status   <= (clx.sat || cly.sat || f1_rsat) ? cfp_pkg::ST_SAT : cfp_pkg::ST_OK;
      end
    end
  end

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v    <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      f1_v    <= in_valid;
      o_valid <= f1_v;
    end
  end

endmodule

[rtl/circle_from_two_or_three_points.sv]
// ----------------------------------------------------------------------------
// circle_from_two_or_three_points: circle through two or three points
// Kind 0 gives the circle on the first two points as diameter, kind 1 the
// circumcircle of all three. Coordinates are signed Q16.16.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: valid, stall, kind and the six coordinates. An item is
//   taken on a rising edge with valid high and stall low.
//   Output channel: res_valid, res_stall, centre, radius and status. A result
//   item leaves on a rising edge with res_valid high and res_stall low.
//   Stages: 8 product stages, 34 divide and square-root stages and 2 result
//   stages lie between acceptance and res_valid.
//   Throughput: one item per cycle while res_stall does not hold the pipeline.
//   Every stage is a register that advances together; the 34 bit-per-stage
//   steps of the offset quotients and the radius search set the depth.
//   Reset clears all valid bits; the pipeline then accepts an item at once.
//   While res_stall holds back a waiting result the whole pipeline holds and
//   stall is raised, so no item is lost or repeated.
//   Status: 0 ok, 1 collinear points (fields zero), 2 result saturated.
// ----------------------------------------------------------------------------
module circle_from_two_or_three_points (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           valid,
  output logic                           stall,
  input  logic                           kind,
  input  logic signed [cfp_pkg::CW-1:0]  ax,
  input  logic signed [cfp_pkg::CW-1:0]  ay,
  input  logic signed [cfp_pkg::CW-1:0]  bx,
  input  logic signed [cfp_pkg::CW-1:0]  by_coord,
  input  logic signed [cfp_pkg::CW-1:0]  cx,
  input  logic signed [cfp_pkg::CW-1:0]  cy,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic signed [cfp_pkg::CW-1:0]  center_x,
  output logic signed [cfp_pkg::CW-1:0]  center_y,
  output logic [cfp_pkg::CW-1:0]         radius,
  output logic [1:0]                     status
);

  logic             adv;
  logic             fr_valid, it_valid;
  cfp_pkg::it_in_t  fr_op;
  cfp_pkg::it_t     it_st;
  cfp_pkg::status_t st_code;

  // advance whenever the output register is free or being emptied
  assign adv   = !res_valid || !res_stall;
  assign stall = !adv;

  cfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (valid),
    .kind     (kind),
    .ax       (ax),
    .ay       (ay),
    .bx       (bx),
    .by_coord (by_coord),
    .cx       (cx),
    .cy       (cy),
    .o_valid  (fr_valid),
    .o_op     (fr_op)
  );

  cfp_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (fr_valid),
    .in_op    (fr_op),
    .o_valid  (it_valid),
    .o_st     (it_st)
  );

  cfp_final u_final (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (it_valid),
    .in_st      (it_st),
    .o_valid    (res_valid),
    .o_center_x (center_x),
    .o_center_y (center_y),
    .o_radius   (radius),
    .o_status   (st_code)
  );

  assign status = st_code;

endmodule

[rtl/cfp_checker.sv]
// ----------------------------------------------------------------------------
// cfp_checker: port checks
// Watches the top level ports for hold, back-pressure, collinear results and reset.
// ----------------------------------------------------------------------------
module cfp_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           stall,
  input  logic                           res_valid,
  input  logic                           res_stall,
  input  logic signed [cfp_pkg::CW-1:0]  center_x,
  input  logic signed [cfp_pkg::CW-1:0]  center_y,
  input  logic [cfp_pkg::CW-1:0]         radius,
  input  logic [1:0]                     status
);

  // hold a stalled result item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(center_x) && $stable(center_y)
      && $stable(radius) && $stable(status))
    else $error("stalled result item changed");

  // a blocked output blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> stall)
    else $error("input accepted while output blocked");

  // collinear points give a zero circle
  a_collinear: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == cfp_pkg::ST_COLLINEAR |-> center_x == '0 && center_y == '0
      && radius == '0)
    else $error("collinear result not zero");

  // reset drops any result item
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result item after reset");

endmodule

bind circle_from_two_or_three_points cfp_checker u_cfp_checker (.*);
